// File: rtl/hbpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbpwm_pkg
// Shared widths, codes and constants of the H-bridge PWM compare driver.
// ----------------------------------------------------------------------------
package hbpwm_pkg;

    // duty full scale and motor count
    localparam int FULL_SCALE  = 1000;
    localparam int MOTOR_COUNT = 2;

    // field widths
    localparam int PERIOD_W = 17;
    localparam int SPEED_W  = 16;
    localparam int HELD_W   = 11;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 3;

    // duty and product widths derived from full scale
    localparam int DUTY_W   = $clog2(FULL_SCALE + 1);
    localparam int SAT_W    = SPEED_W + 2;
    localparam int PROD_W   = PERIOD_W + DUTY_W;

    // reciprocal of full scale, scaled so that the estimate is low by one at most
    localparam int RECIP_SH = PROD_W + DUTY_W;
    localparam int RECIP_W  = PROD_W + 2;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SH) / FULL_SCALE;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(FULL_SCALE);
    localparam logic [PROD_W-1:0] FULL_PROD = PROD_W'(FULL_SCALE);
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000);

    // operation codes
    localparam logic [OP_W-1:0] OP_DRIVE = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_BRAKE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_L = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_R = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_L  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_R  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_L = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_R = 3'd5;

endpackage

// File: rtl/hbridge_pwm_compare_driver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbridge_pwm_compare_driver_unit
// Maps drive, stop and brake commands of two H-bridge motors to timer
// compare values for both bridge inputs, with slow or fast decay.
// ----------------------------------------------------------------------------
// An accepted input beat passes the stage registers A, B and C and then the output register.
// Throughput: one beat per cycle; the four stages stall together only while
// the output register holds a beat the sink has not taken.
// The division by full scale is a reciprocal multiply and a correction stage.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: period 1000 ticks, slow decay, no inversion.
module hbridge_pwm_compare_driver_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command beats
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // speed[15:0]
    input  logic [2:0]                        s_axis_tuser,  // operation[1:0], motor[2]
    // result beats
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [47:0]                       m_axis_tdata,  // compare_first[16:0],
                                                             // compare_second[33:17],
                                                             // speed_held[44:34]
    output logic [0:0]                        m_axis_tuser,  // motor_out[0]
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [hbpwm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hbpwm_pkg::PERIOD_W-1:0]    i_cfg_data
);

    localparam int PW = hbpwm_pkg::PERIOD_W;
    localparam int DW = hbpwm_pkg::DUTY_W;
    localparam int XW = hbpwm_pkg::PROD_W;
    localparam int RW = hbpwm_pkg::RECIP_W;
    localparam int SW = hbpwm_pkg::SAT_W;
    localparam int HW = hbpwm_pkg::HELD_W;

    // configuration registers
    logic [PW-1:0] r_period [hbpwm_pkg::MOTOR_COUNT];
    logic          r_decay  [hbpwm_pkg::MOTOR_COUNT];
    logic          r_invert [hbpwm_pkg::MOTOR_COUNT];

    // pipeline stage registers
    logic                        r_a_vld, r_b_vld, r_c_vld, r_o_vld;
    logic [hbpwm_pkg::OP_W-1:0]  r_a_op;
    logic                        r_a_motor, r_b_motor, r_c_motor, r_o_motor;
    logic signed [hbpwm_pkg::SPEED_W-1:0] r_a_speed;
    logic [HW-1:0]               r_b_held, r_c_held, r_o_held;
    logic [PW-1:0]               r_b_period, r_c_period;
    logic [XW-1:0]               r_b_prod [2];
    logic [XW-1:0]               r_c_prod [2];
    logic [PW-1:0]               r_c_qe   [2];
    logic [PW-1:0]               r_o_cmp  [2];

    logic                        w_adv;
    logic signed [SW-1:0]        w_speed_ext, w_sat, w_abs, w_lim;
    logic [DW-1:0]               w_mag;
    logic                        w_fwd;
    logic [PW-1:0]               w_period;
    logic [DW-1:0]               w_duty     [2];
    logic [DW-1:0]               w_duty_clp [2];
    logic [HW-1:0]               w_held;
    logic [XW+RW-1:0]            w_full     [2];
    logic [XW-1:0]               w_rem      [2];
    logic [PW-1:0]               w_quo      [2];

    // the whole pipeline moves unless the output beat is stalled
    assign w_adv         = !r_o_vld || m_axis_tready;
    assign s_axis_tready = w_adv;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period[0] <= hbpwm_pkg::PERIOD_RST;
            r_period[1] <= hbpwm_pkg::PERIOD_RST;
            r_decay[0]  <= 1'b0;
            r_decay[1]  <= 1'b0;
            r_invert[0] <= 1'b0;
            r_invert[1] <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hbpwm_pkg::REG_PERIOD_L: r_period[0] <= i_cfg_data;
                hbpwm_pkg::REG_PERIOD_R: r_period[1] <= i_cfg_data;
                hbpwm_pkg::REG_DECAY_L:  r_decay[0]  <= i_cfg_data[0];
                hbpwm_pkg::REG_DECAY_R:  r_decay[1]  <= i_cfg_data[0];
                hbpwm_pkg::REG_INVERT_L: r_invert[0] <= i_cfg_data[0];
                hbpwm_pkg::REG_INVERT_R: r_invert[1] <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid bits of the four stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_o_vld <= r_c_vld;
        end
    end

    // saturation, direction and decay mapping to two duties
    always_comb begin
        w_lim       = SW'(hbpwm_pkg::FULL_SCALE);
        w_speed_ext = SW'(r_a_speed);
        if (w_speed_ext > w_lim) begin
            w_sat = w_lim;
        end else if (w_speed_ext < -w_lim) begin
            w_sat = -w_lim;
        end else begin
            w_sat = w_speed_ext;
        end
        w_abs    = (w_sat < 0) ? -w_sat : w_sat;
        w_mag    = w_abs[DW-1:0];
        w_fwd    = (w_sat > 0) ^ r_invert[r_a_motor];
        w_period = r_period[r_a_motor];
        w_duty[0] = '0;
        w_duty[1] = '0;
        w_held    = '0;
        case (r_a_op)
            hbpwm_pkg::OP_DRIVE: begin
                w_held = w_sat[HW-1:0];
                if (w_sat != 0) begin
                    if (!r_decay[r_a_motor]) begin
                        w_duty[0] = w_fwd ? hbpwm_pkg::FULL_DUTY
                                          : hbpwm_pkg::FULL_DUTY - w_mag;
                        w_duty[1] = w_fwd ? hbpwm_pkg::FULL_DUTY - w_mag
                                          : hbpwm_pkg::FULL_DUTY;
                    end else begin
                        w_duty[0] = w_fwd ? w_mag : '0;
                        w_duty[1] = w_fwd ? '0 : w_mag;
                    end
                end
            end
            hbpwm_pkg::OP_BRAKE: begin
                w_duty[0] = hbpwm_pkg::FULL_DUTY;
                w_duty[1] = hbpwm_pkg::FULL_DUTY;
            end
            // stop and the unused code coast
            default: ;
        endcase
        // duty never above full scale
        for (int i = 0; i < 2; i++) begin
            w_duty_clp[i] = (w_duty[i] > hbpwm_pkg::FULL_DUTY) ? hbpwm_pkg::FULL_DUTY
                                                               : w_duty[i];
        end
    end

    // reciprocal multiply and remainder correction per bridge input
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_full[i] = (XW + RW)'(r_b_prod[i]) * (XW + RW)'(hbpwm_pkg::RECIP);
            w_rem[i]  = r_c_prod[i] - XW'(r_c_qe[i]) * hbpwm_pkg::FULL_PROD;
            w_quo[i]  = r_c_qe[i] + PW'(w_rem[i] >= hbpwm_pkg::FULL_PROD);
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // input beat
            r_a_op    <= s_axis_tuser[1:0];
            r_a_motor <= s_axis_tuser[2];
            r_a_speed <= s_axis_tdata;
            // duty times period
            r_b_motor  <= r_a_motor;
            r_b_held   <= w_held;
            r_b_period <= w_period;
            for (int i = 0; i < 2; i++) begin
                r_b_prod[i] <= XW'(w_period) * XW'(w_duty_clp[i]);
            end
            // quotient estimate
            r_c_motor  <= r_b_motor;
            r_c_held   <= r_b_held;
            r_c_period <= r_b_period;
            for (int i = 0; i < 2; i++) begin
                r_c_prod[i] <= r_b_prod[i];
                r_c_qe[i]   <= w_full[i][hbpwm_pkg::RECIP_SH +: PW];
            end
            // compare values
            r_o_motor <= r_c_motor;
            r_o_held  <= r_c_held;
            for (int i = 0; i < 2; i++) begin
                r_o_cmp[i] <= r_c_period - w_quo[i];
            end
        end
    end

    // result beat
    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = r_o_motor;
    assign m_axis_tdata  = {(48 - 2 * PW - HW)'(0), r_o_held, r_o_cmp[1], r_o_cmp[0]};

`ifndef SYNTHESIS
    // a beat leaving the last compute stage shows up on the output next cycle
    a_beat_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld && w_adv |=> m_axis_tvalid)
        else $error("result beat lost between compute stage and output");

    // uncorrected remainder lies below twice full scale for both inputs
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (w_rem[0] < hbpwm_pkg::FULL_PROD + hbpwm_pkg::FULL_PROD) &&
                    (w_rem[1] < hbpwm_pkg::FULL_PROD + hbpwm_pkg::FULL_PROD))
        else $error("reciprocal estimate off by more than one");

    // the scaled duty never exceeds the period
    a_quo_le_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (w_quo[0] <= r_c_period) && (w_quo[1] <= r_c_period))
        else $error("scaled duty above period");
`endif

endmodule
